### rtl/cata_pkg.sv
// Package for the card access table locker: sizes, operation and status codes,
// item structs and the ID masking helpers.
// No dependencies; imported by card_access_table_locker.
`default_nettype none

package cata_pkg;

    // Table size and derived widths
    localparam int TABLE_DEPTH = 16;
    localparam int ID_BYTES    = 10;
    localparam int ID_W        = 8 * ID_BYTES;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    // wide enough for both the entry count and a 4-bit index field
    localparam int CMP_W       = (CNT_W > 4) ? CNT_W : 4;

    // Operation codes
    localparam logic [1:0] OP_PRESENT = 2'd0;
    localparam logic [1:0] OP_ADD     = 2'd1;
    localparam logic [1:0] OP_REMOVE  = 2'd2;

    // Status codes
    localparam logic [2:0] ST_LOCKED    = 3'd0;
    localparam logic [2:0] ST_UNLOCKED  = 3'd1;
    localparam logic [2:0] ST_DENIED    = 3'd2;
    localparam logic [2:0] ST_ADDED     = 3'd3;
    localparam logic [2:0] ST_DUPLICATE = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;
    localparam logic [2:0] ST_REMOVED   = 3'd6;
    localparam logic [2:0] ST_BAD_INDEX = 3'd7;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] uid_low;
        logic [15:0] uid_high;
        logic [3:0]  uid_size;
        logic [3:0]  table_index;
        logic [3:0]  owner_index;
    } t_in_item;

    typedef struct packed {
        logic [2:0] status;
        logic       locker_occupied;
        logic [4:0] entry_count;
    } t_out_item;

    // One table entry: ID bytes (zero beyond size) and size
    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [3:0]      size;
    } t_entry;

    // Card length limited to the longest ID
    function automatic logic [3:0] clamp_len(input logic [3:0] n);
        return (n > 4'(ID_BYTES)) ? 4'(ID_BYTES) : n;
    endfunction

    // Byte mask covering the first n bytes of an ID
    function automatic logic [ID_W-1:0] id_mask(input logic [3:0] n);
        logic [ID_W-1:0] m;
        m = '0;
        for (int b = 0; b < ID_BYTES; b++) begin
            m[b*8 +: 8] = (4'(b) < n) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

### rtl/card_access_table_locker.sv
// Card access table locker: authorized-card table with add, remove and
// present operations, plus the locker's occupied flag and owner ID.
// Depends on cata_pkg.
//
// One item is worked at a time; o_in_stall is high from acceptance until the
// result is loaded into the output register. The table sits in a memory with
// one write and one registered read port, and a single prefix comparator is
// shared by the table scan and the owner check. A present on an occupied
// locker goes straight to the owner check; a bad-index remove or an unused
// operation goes straight to the result. A scan reads one entry per cycle
// and compares it from the registered read. A present that matches fetches
// the owner entry and locks; an add that matches reports a duplicate; with
// no match a present is denied and an add is appended, or reports full. A
// remove moves each later entry down by one, one entry moved per cycle;
// removing the last entry only lowers the count. A stalled result holds
// the block in its last state until the output register frees; the result
// register frees the input side as soon as the result is loaded.
`default_nettype none

module card_access_table_locker
    import cata_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output t_out_item  o_out_item
);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_OWNLD  = 3'd2;
    localparam logic [2:0] S_OWNCMP = 3'd3;
    localparam logic [2:0] S_SHIFT  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    // Control state
    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_occupied, n_occupied;
    logic [CNT_W-1:0] r_ridx, n_ridx;
    logic [CNT_W-1:0] r_widx, n_widx;
    logic             r_pend, n_pend;
    logic             r_out_valid;

    // Item payload
    logic [1:0]       r_op, n_op;
    logic [ID_W-1:0]  r_card, n_card;
    logic [3:0]       r_len, n_len;
    logic [3:0]       r_tix, n_tix;
    logic [3:0]       r_oix, n_oix;
    logic [2:0]       r_status, n_status;

    // Owner
    logic [ID_W-1:0]  r_owner_id, n_owner_id;
    logic [3:0]       r_owner_size, n_owner_size;

    t_out_item        r_out_item;

    // Table memory
    t_entry           mem [TABLE_DEPTH];
    t_entry           r_rd;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_data;

    // Shared prefix comparator
    logic [ID_W-1:0]  cmp_a;
    logic [3:0]       cmp_len;
    logic             cmp_eq;
    logic             hit;
    logic [IDX_W-1:0] sel;
    logic             out_free;
    logic [3:0]       in_len;

    assign cmp_a   = (r_state == S_OWNCMP) ? r_owner_id : r_rd.id;
    assign cmp_len = (r_state == S_OWNCMP) ? r_owner_size : r_len;
    assign cmp_eq  = (((cmp_a ^ r_card) & id_mask(cmp_len)) == '0);
    assign hit     = r_pend && cmp_eq;

    // Owner entry: owner_index, or entry 0 when out of range
    assign sel = (CMP_W'(r_oix) < CMP_W'(r_count)) ? IDX_W'(r_oix) : '0;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign in_len     = clamp_len(i_in_item.uid_size);
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_occupied   = r_occupied;
        n_ridx       = r_ridx;
        n_widx       = r_widx;
        n_pend       = r_pend;
        n_op         = r_op;
        n_card       = r_card;
        n_len        = r_len;
        n_tix        = r_tix;
        n_oix        = r_oix;
        n_status     = r_status;
        n_owner_id   = r_owner_id;
        n_owner_size = r_owner_size;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = r_widx[IDX_W-1:0];
        wr_data      = r_rd;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op   = i_in_item.operation;
                    n_len  = in_len;
                    n_card = {i_in_item.uid_high, i_in_item.uid_low} & id_mask(in_len);
                    n_tix  = i_in_item.table_index;
                    n_oix  = i_in_item.owner_index;
                    n_ridx = '0;
                    n_pend = 1'b0;
                    case (i_in_item.operation)
                        OP_PRESENT: begin
                            n_state = r_occupied ? S_OWNCMP : S_SCAN;
                        end
                        OP_ADD: begin
                            n_state = S_SCAN;
                        end
                        OP_REMOVE: begin
                            if (CMP_W'(i_in_item.table_index) < CMP_W'(r_count)) begin
                                n_widx  = CNT_W'(i_in_item.table_index);
                                n_ridx  = CNT_W'(i_in_item.table_index) + CNT_W'(1);
                                n_state = S_SHIFT;
                            end else begin
                                n_status = ST_BAD_INDEX;
                                n_state  = S_DONE;
                            end
                        end
                        default: begin
                            n_status = ST_DENIED;
                            n_state  = S_DONE;
                        end
                    endcase
                end
            end

            // One entry read per cycle, compared in the next cycle
            S_SCAN: begin
                if (hit) begin
                    n_pend = 1'b0;
                    if (r_op == OP_PRESENT) begin
                        rd_addr = sel;
                        n_state = S_OWNLD;
                    end else begin
                        n_status = ST_DUPLICATE;
                        n_state  = S_DONE;
                    end
                end else if (r_ridx < r_count) begin
                    rd_addr = r_ridx[IDX_W-1:0];
                    n_ridx  = r_ridx + CNT_W'(1);
                    n_pend  = 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_DONE;
                    if (r_op == OP_PRESENT) begin
                        n_status = ST_DENIED;
                    end else if (r_count == CNT_W'(TABLE_DEPTH)) begin
                        n_status = ST_FULL;
                    end else begin
                        wr_en        = 1'b1;
                        wr_addr      = r_count[IDX_W-1:0];
                        wr_data.id   = r_card;
                        wr_data.size = r_len;
                        n_count      = r_count + CNT_W'(1);
                        n_status     = ST_ADDED;
                    end
                end
            end

            // Owner entry fetched: lock
            S_OWNLD: begin
                n_owner_id   = r_rd.id;
                n_owner_size = r_rd.size;
                n_occupied   = 1'b1;
                n_status     = ST_LOCKED;
                n_state      = S_DONE;
            end

            // Card against owner
            S_OWNCMP: begin
                n_state = S_DONE;
                if (r_owner_size != 4'd0 && cmp_eq) begin
                    n_occupied   = 1'b0;
                    n_owner_id   = '0;
                    n_owner_size = 4'd0;
                    n_status     = ST_UNLOCKED;
                end else begin
                    n_status = ST_DENIED;
                end
            end

            // Compaction: read entry i+1, write it to entry i next cycle
            S_SHIFT: begin
                if (r_pend) begin
                    wr_en  = 1'b1;
                    n_widx = r_widx + CNT_W'(1);
                end
                if (r_ridx < r_count) begin
                    rd_addr = r_ridx[IDX_W-1:0];
                    n_ridx  = r_ridx + CNT_W'(1);
                    n_pend  = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_count  = r_count - CNT_W'(1);
                        n_status = ST_REMOVED;
                        n_state  = S_DONE;
                    end
                end
            end

            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_occupied   <= 1'b0;
            r_owner_id   <= '0;
            r_owner_size <= 4'd0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_occupied   <= n_occupied;
            r_owner_id   <= n_owner_id;
            r_owner_size <= n_owner_size;
            r_pend       <= n_pend;
            // load a new result, else drop one taken by the receiver
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_ridx   <= n_ridx;
        r_widx   <= n_widx;
        r_op     <= n_op;
        r_card   <= n_card;
        r_len    <= n_len;
        r_tix    <= n_tix;
        r_oix    <= n_oix;
        r_status <= n_status;
        if (r_state == S_DONE && out_free) begin
            r_out_item.status          <= r_status;
            r_out_item.locker_occupied <= r_occupied;
            r_out_item.entry_count     <= 5'(r_count);
        end
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### tb/card_access_table_locker_tb.sv
// Self-checking testbench for card_access_table_locker: a directed run, a back-to-back
// fill under a long output hold, then random items of all opcodes with random idling.
// Depends on cata_pkg and card_access_table_locker.
`default_nettype none

module card_access_table_locker_tb;
    import cata_pkg::*;

    localparam logic [1:0]      OP_UNUSED    = 2'd3;
    localparam logic [ID_W-1:0] ID_ALL_ONES  = '1;
    localparam int unsigned     RANDOM_ITEMS = 810;
    localparam int unsigned     LONG_HOLD    = 300;
    localparam int unsigned     IDLE_LIMIT   = 4000;
    localparam int unsigned     DRAIN_CYCLES = 25;

    // Shadow of the locker state; predicts the reply of each item and checks replies
    class locker_shadow;
        logic [ID_W-1:0] ids [TABLE_DEPTH];
        logic [3:0]      sizes [TABLE_DEPTH];
        int unsigned     n_entries;
        bit              occupied;
        logic [ID_W-1:0] owner_id;
        logic [3:0]      owner_size;
        t_out_item       pending_replies [$];
        int unsigned     fails;
        int unsigned     replies_checked;
        int unsigned     status_tally [8];

        function new();
            n_entries       = 0;
            occupied        = 1'b0;
            owner_id        = '0;
            owner_size      = '0;
            fails           = 0;
            replies_checked = 0;
            foreach (status_tally[s]) status_tally[s] = 0;
        endfunction

        // Ones over the first n bytes of an ID
        static function logic [ID_W-1:0] prefix_mask(int unsigned n);
            if (n >= ID_BYTES) return '1;
            return (ID_W'(1) << (8 * n)) - ID_W'(1);
        endfunction

        // Any entry agreeing with the card on the masked bytes
        function bit table_holds(logic [ID_W-1:0] card, logic [ID_W-1:0] m);
            for (int e = 0; e < n_entries; e++) begin
                if (((ids[e] ^ card) & m) == '0) return 1'b1;
            end
            return 1'b0;
        endfunction

        function void accept_request(t_in_item it);
            int unsigned     len;
            int unsigned     sel;
            logic [ID_W-1:0] m;
            logic [ID_W-1:0] card;
            t_out_item       r;
            len      = (it.uid_size > ID_BYTES) ? ID_BYTES : it.uid_size;
            m        = prefix_mask(len);
            card     = {it.uid_high, it.uid_low} & m;
            r.status = ST_DENIED;
            case (it.operation)
                OP_PRESENT: begin
                    if (!occupied) begin
                        if (table_holds(card, m)) begin
                            // out-of-range owner index falls back to entry 0
                            sel        = (it.owner_index < n_entries) ? it.owner_index : 0;
                            occupied   = 1'b1;
                            owner_id   = ids[sel];
                            owner_size = sizes[sel];
                            r.status   = ST_LOCKED;
                        end
                    end else if (owner_size != 0 &&
                                 ((card ^ owner_id) & prefix_mask(owner_size)) == '0) begin
                        occupied   = 1'b0;
                        owner_id   = '0;
                        owner_size = '0;
                        r.status   = ST_UNLOCKED;
                    end
                end
                OP_ADD: begin
                    if (table_holds(card, m)) begin
                        r.status = ST_DUPLICATE;
                    end else if (n_entries >= TABLE_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        ids[n_entries]   = card;
                        sizes[n_entries] = 4'(len);
                        n_entries++;
                        r.status = ST_ADDED;
                    end
                end
                OP_REMOVE: begin
                    if (it.table_index < n_entries) begin
                        // compact: later entries move down by one
                        for (int e = it.table_index; e + 1 < n_entries; e++) begin
                            ids[e]   = ids[e + 1];
                            sizes[e] = sizes[e + 1];
                        end
                        n_entries--;
                        ids[n_entries]   = '0;
                        sizes[n_entries] = '0;
                        r.status = ST_REMOVED;
                    end else begin
                        r.status = ST_BAD_INDEX;
                    end
                end
                default: ;
            endcase
            r.locker_occupied = occupied;
            r.entry_count     = 5'(n_entries);
            pending_replies.push_back(r);
        endfunction

        function void compare_field(string name, logic [4:0] want, logic [4:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                fails++;
            end
        endfunction

        function void check_reply(t_out_item got);
            t_out_item want;
            if (pending_replies.size() == 0) begin
                $error("reply with no item outstanding: status %0d", got.status);
                fails++;
                return;
            end
            want = pending_replies.pop_front();
            compare_field("status", 5'(want.status), 5'(got.status));
            compare_field("locker_occupied", 5'(want.locker_occupied),
                          5'(got.locker_occupied));
            compare_field("entry_count", want.entry_count, got.entry_count);
            status_tally[want.status]++;
            replies_checked++;
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    locker_shadow shadow;
    bit           no_idle     = 1'b0;
    bit           hold_req    = 1'b0;
    bit           holding     = 1'b0;
    int unsigned  idle_cycles = 0;
    int unsigned  items_sent  = 0;

    card_access_table_locker dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Idle length: mostly none or short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [ID_W-1:0] random_id();
        return {16'($urandom), $urandom, $urandom};
    endfunction

    // Keep the first n bytes of id, random bytes past them
    function automatic logic [ID_W-1:0] keep_prefix(logic [ID_W-1:0] id, int unsigned n);
        logic [ID_W-1:0] m;
        m = locker_shadow::prefix_mask(n);
        return (random_id() & ~m) | (id & m);
    endfunction

    function automatic t_in_item card_item(logic [1:0] op, logic [ID_W-1:0] id,
                                           logic [3:0] size, logic [3:0] tix = '0,
                                           logic [3:0] oix = '0);
        t_in_item it;
        it.operation                 = op;
        {it.uid_high, it.uid_low}    = id;
        it.uid_size                  = size;
        it.table_index               = tix;
        it.owner_index               = oix;
        return it;
    endfunction

    // Mostly well-formed traffic: known cards, owner cards, in-range removes
    function automatic t_in_item random_item();
        t_in_item    it;
        int unsigned pick;
        int unsigned e;
        it = card_item(OP_PRESENT, random_id(), 4'($urandom_range(0, 15)),
                       4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            if (shadow.occupied && $urandom_range(0, 99) < 60) begin
                it.uid_size = 4'($urandom_range(shadow.owner_size, 15));
                {it.uid_high, it.uid_low} = keep_prefix(shadow.owner_id, shadow.owner_size);
            end else if (!shadow.occupied && shadow.n_entries != 0 &&
                         $urandom_range(0, 99) < 70) begin
                e = $urandom_range(0, shadow.n_entries - 1);
                it.uid_size = 4'($urandom_range(1, shadow.sizes[e]));
                {it.uid_high, it.uid_low} = keep_prefix(shadow.ids[e], it.uid_size);
            end
        end else if (pick < 75) begin
            it.operation = OP_ADD;
            if (shadow.n_entries == 0 && it.uid_size == 0) begin
                // a zero-length owner would jam the locker; kept for the last phase
                it.uid_size = 4'd1;
            end else if (shadow.n_entries != 0 && $urandom_range(0, 99) < 15) begin
                e = $urandom_range(0, shadow.n_entries - 1);
                it.uid_size = 4'($urandom_range(1, shadow.sizes[e]));
                {it.uid_high, it.uid_low} = keep_prefix(shadow.ids[e], it.uid_size);
            end
        end else if (pick < 95) begin
            it.operation = OP_REMOVE;
            if (shadow.n_entries != 0 && $urandom_range(0, 99) < 75) begin
                it.table_index = 4'($urandom_range(0, shadow.n_entries - 1));
            end
        end else begin
            it.operation = OP_UNUSED;
        end
        return it;
    endfunction

    // Offer one item until taken, then idle for gap cycles
    task automatic send_item(input t_in_item it, input int unsigned gap);
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        shadow.accept_request(it);
        items_sent++;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering until every outstanding reply is back
    task automatic drain_replies();
        in_valid <= 1'b0;
        do @(posedge clk); while (shadow.pending_replies.size() != 0);
    endtask

    // Reply checker and handshake watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) shadow.check_reply(out_item);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Reply side: random stall runs, open bursts, one long hold on request
    initial begin : reply_sink
        int unsigned n;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_req) begin
                holding = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                holding  = 1'b0;
                hold_req = 1'b0;
            end else if (no_idle) begin
                out_stall <= 1'b0;
                @(posedge clk);
            end else begin
                n = pick_gap();
                if (n != 0) begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        logic [ID_W-1:0] id;
        shadow = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, every operation, clamping, wraps and compaction
        send_item(card_item(OP_PRESENT, ID_ALL_ONES, 4'd10), pick_gap());
        send_item(card_item(OP_REMOVE, '0, 4'd0, 4'd0), pick_gap());
        send_item(card_item(OP_UNUSED, ID_ALL_ONES, 4'd15, 4'd15, 4'd15), pick_gap());
        send_item(card_item(OP_ADD, ID_ALL_ONES, 4'd15), pick_gap());
        send_item(card_item(OP_ADD, '0, 4'd10), pick_gap());
        send_item(card_item(OP_ADD, 80'h0123_4567_89AB_CDFF_FFFF, 4'd3), pick_gap());
        send_item(card_item(OP_ADD, random_id(), 4'd0), pick_gap());
        // zero-length card matches any entry; owner index 15 wraps to entry 0
        send_item(card_item(OP_PRESENT, random_id(), 4'd0, 4'd0, 4'd15), pick_gap());
        send_item(card_item(OP_PRESENT, '0, 4'd10), pick_gap());
        send_item(card_item(OP_PRESENT, ID_ALL_ONES, 4'd0), pick_gap());
        send_item(card_item(OP_PRESENT, ID_ALL_ONES, 4'd10), pick_gap());
        send_item(card_item(OP_PRESENT, '0, 4'd10, 4'd0, 4'd1), pick_gap());
        send_item(card_item(OP_ADD, 80'h5555_AAAA_AAAA_AAAA_AAAA, 4'd9), pick_gap());
        send_item(card_item(OP_PRESENT, 80'hFFFF_0000_0000_0000_0000, 4'd12), pick_gap());
        send_item(card_item(OP_REMOVE, ID_ALL_ONES, 4'd10, 4'd15, 4'd15), pick_gap());
        send_item(card_item(OP_REMOVE, '0, 4'd0, 4'd0), pick_gap());
        send_item(card_item(OP_PRESENT, ID_ALL_ONES, 4'd10), pick_gap());
        drain_replies();

        // long output hold while the table is filled back to back
        hold_req = 1'b1;
        while (!holding) @(posedge clk);
        while (shadow.n_entries < TABLE_DEPTH) begin
            id = random_id();
            id[7:0] = 8'h10 + 8'(shadow.n_entries);
            send_item(card_item(OP_ADD, id, 4'd10), 0);
        end
        id = random_id();
        id[7:0] = 8'hF0;
        send_item(card_item(OP_ADD, id, 4'd10), 0);
        send_item(card_item(OP_PRESENT, random_id(), 4'd0, 4'd0, 4'd15), 0);
        send_item(card_item(OP_PRESENT, shadow.owner_id, shadow.owner_size), 0);
        send_item(card_item(OP_REMOVE, random_id(), 4'd7, 4'd15), 0);
        send_item(card_item(OP_REMOVE, random_id(), 4'd7, 4'd5), 0);
        drain_replies();

        // random traffic with open stretches and periodic full drains
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            no_idle = (k % 160) >= 120;
            if (k % 300 == 299) drain_replies();
            send_item(random_item(), pick_gap());
        end
        no_idle = 1'b0;

        // a zero-length owner: the locker can no longer be opened
        if (shadow.occupied) begin
            send_item(card_item(OP_PRESENT, shadow.owner_id, shadow.owner_size), pick_gap());
        end
        while (shadow.n_entries != 0) begin
            send_item(card_item(OP_REMOVE, random_id(), 4'($urandom_range(0, 15)), 4'd0),
                      pick_gap());
        end
        send_item(card_item(OP_ADD, random_id(), 4'd0), pick_gap());
        send_item(card_item(OP_PRESENT, random_id(), 4'd0, 4'd0, 4'd9), pick_gap());
        send_item(card_item(OP_PRESENT, '0, 4'd0), pick_gap());
        send_item(card_item(OP_PRESENT, random_id(), 4'd10), 0);
        drain_replies();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d items and checked %0d replies, including a %0d-cycle output hold.",
                 items_sent, shadow.replies_checked, LONG_HOLD);
        $display("Replies: locked %0d unlocked %0d denied %0d added %0d dup %0d full %0d %s",
                 shadow.status_tally[ST_LOCKED], shadow.status_tally[ST_UNLOCKED],
                 shadow.status_tally[ST_DENIED], shadow.status_tally[ST_ADDED],
                 shadow.status_tally[ST_DUPLICATE], shadow.status_tally[ST_FULL],
                 $sformatf("removed %0d bad index %0d", shadow.status_tally[ST_REMOVED],
                           shadow.status_tally[ST_BAD_INDEX]));
        if (shadow.fails == 0 && shadow.pending_replies.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
